// ===== src/lcvf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcvf_pkg: shared types, constants and helpers
// Payload structs, pipeline cell structs, register map and the rounding,
// saturation and magnitude helpers of the limit-cycle velocity field block.
// ----------------------------------------------------------------------------
package lcvf_pkg;

   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 31;
   localparam int PIPE_STAGES = 2 * SQRT_STEPS + 2 * DIV_STEPS + 14;
   localparam int ADDR_W      = 5;

   typedef enum logic [2:0] {
      REG_GAIN,
      REG_RADIUS,
      REG_OMEGA,
      REG_OFS_X,
      REG_OFS_Y,
      REG_OFS_Z,
      REG_LIMIT
   } reg_index_type;

   typedef logic signed [65:0] wide_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
      logic signed [31:0] centre_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic               was_limited;
   } rsp_type;

   // one digit step of the square root: radicand left, remainder, root so far
   typedef struct packed {
      logic [63:0] n;
      logic [33:0] rem;
      logic [31:0] root;
   } sqrt_cell_type;

   // one bit step of the division: remainder, divisor, low dividend / quotient
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] den;
      logic [30:0] qn;
   } div_cell_type;

   // shift right, rounding to nearest with ties away from zero
   function automatic wide_type shr_rnd(input wide_type v, input int unsigned k);
      wide_type mag;
      wide_type m;
      mag = v[65] ? -v : v;
      m   = (mag + (66'sd1 <<< (k - 1))) >>> k;
      return v[65] ? -m : m;
   endfunction

   function automatic logic signed [31:0] sat32(input wide_type v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return $signed(v[31:0]);
      end
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

// ===== src/lcvf_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// lcvf_sqrt_cell: one digit of an integer square root
// Takes two radicand bits, tries the next root bit and registers the
// partial result for the next cell of the chain.
// ----------------------------------------------------------------------------
module lcvf_sqrt_cell import lcvf_pkg::*; (
   input  logic          clock,
   input  logic          advance,
   input  sqrt_cell_type prev_cell,
   output sqrt_cell_type next_cell
);

   sqrt_cell_type cell_ff;
   sqrt_cell_type cell_in;
   logic [35:0]   part;
   logic [35:0]   trial;

   always_comb begin
      part      = {prev_cell.rem, prev_cell.n[63:62]};
      trial     = {2'b00, prev_cell.root, 2'b01};
      cell_in.n = {prev_cell.n[61:0], 2'b00};
      if (part >= trial) begin
         cell_in.rem  = 34'(part - trial);
         cell_in.root = {prev_cell.root[30:0], 1'b1};
      end else begin
         cell_in.rem  = part[33:0];
         cell_in.root = {prev_cell.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign next_cell = cell_ff;

endmodule

// ===== src/lcvf_div_cell.sv =====
// ----------------------------------------------------------------------------
// lcvf_div_cell: one bit of a restoring divider
// Brings down the next dividend bit, subtracts the divisor where it fits
// and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module lcvf_div_cell import lcvf_pkg::*; (
   input  logic         clock,
   input  logic         advance,
   input  div_cell_type prev_cell,
   output div_cell_type next_cell
);

   div_cell_type cell_ff;
   div_cell_type cell_in;
   logic [32:0]  part;

   always_comb begin
      part        = {prev_cell.rem, prev_cell.qn[30]};
      cell_in.den = prev_cell.den;
      if (part >= {1'b0, prev_cell.den}) begin
         cell_in.rem = 32'(part - {1'b0, prev_cell.den});
         cell_in.qn  = {prev_cell.qn[29:0], 1'b1};
      end else begin
         cell_in.rem = part[31:0];
         cell_in.qn  = {prev_cell.qn[29:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign next_cell = cell_ff;

endmodule

// ===== src/limit_cycle_velocity_field.sv =====
// ----------------------------------------------------------------------------
// limit_cycle_velocity_field: velocity toward a circular limit cycle
// Turns a position sample and a circle centre into a speed-limited
// velocity vector, Q16.16 fixed point, one sample per clock while the output is not held.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beats (req_valid/req_ready) carry position and centre; output
//    beats (rsp_valid/rsp_ready) carry the velocity and the limited flag.
//  - One result per input, in order. A new beat is taken every cycle unless the output holds.
//  - The pipeline has 140 register stages: two 32-cell square root chains,
//    two 31-cell divider sections (two lanes, then three) and 14 arithmetic
//    stages. rsp_valid is a valid bit that moves through every stage with
//    its data.
//  - The whole pipeline advances together; when a result sits in the
//    output register and rsp_ready is low, the pipeline holds and
//    req_ready drops until the beat is taken.
//  - Registers sit on an APB port (pready always high); the user must write
//    them only while the block is idle (not enforced by the block). Reset
//    clears the valid bits and loads defaults (gain 1.0, everything else zero).
//  - With a zero speed limit any nonzero vector is limited to zero.
// ----------------------------------------------------------------------------
module limit_cycle_velocity_field import lcvf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
   } dvec_type;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
   } vvec_type;

   typedef struct packed {
      logic [63:0] sqx;
      logic [63:0] sqy;
      dvec_type    d;
   } sq_stage_type;

   typedef struct packed {
      logic [63:0] sum;
      dvec_type    d;
   } sum_stage_type;

   typedef struct packed {
      logic [61:0]        numc;
      logic [61:0]        nums;
      logic [31:0]        den;
      logic               zero;
      logic               sx;
      logic               sy;
      logic signed [57:0] pprod;
      logic signed [56:0] zprod;
   } dir_stage_type;

   typedef struct packed {
      logic signed [31:0] p;
      logic signed [31:0] vz;
      logic               zero;
      logic               sx;
      logic               sy;
   } dir_side_type;

   typedef struct packed {
      logic [61:0]  numc;
      logic [61:0]  nums;
      logic [31:0]  den;
      dir_side_type sb;
   } div_in_stage_type;

   typedef struct packed {
      logic signed [31:0] c;
      logic signed [31:0] s;
      logic signed [31:0] p;
      logic signed [31:0] vz;
   } cs_stage_type;

   typedef struct packed {
      logic signed [63:0] pc;
      logic signed [63:0] qs;
      logic signed [63:0] ps;
      logic signed [63:0] qc;
      logic signed [31:0] vz;
   } prod_stage_type;

   typedef struct packed {
      logic signed [64:0] x;
      logic signed [64:0] y;
      logic signed [31:0] vz;
   } xy_stage_type;

   typedef struct packed {
      logic [63:0] sq0;
      logic [63:0] sq1;
      logic [63:0] sq2;
      vvec_type    v;
   } vsq_stage_type;

   typedef struct packed {
      logic [63:0] s01;
      logic [63:0] sq2;
      vvec_type    v;
   } vpart_stage_type;

   typedef struct packed {
      logic [63:0] sum;
      vvec_type    v;
   } vsum_stage_type;

   typedef struct packed {
      vvec_type v;
      logic     lim;
   } lim_side_type;

   typedef struct packed {
      logic [61:0]  pr0;
      logic [61:0]  pr1;
      logic [61:0]  pr2;
      logic [31:0]  den;
      lim_side_type sb;
   } scale_stage_type;

   // configuration registers
   logic        [23:0] gain_ff;
   logic        [30:0] radius_ff;
   logic signed [23:0] omega_ff;
   logic signed [31:0] ofs_x_ff;
   logic signed [31:0] ofs_y_ff;
   logic signed [31:0] ofs_z_ff;
   logic        [30:0] limit_ff;

   logic signed [55:0] rw_prod;
   logic signed [31:0] qrw_ff;
   logic        [61:0] lsq_ff;

   logic                   advance;
   logic [PIPE_STAGES-1:0] vld_ff;

   dvec_type          a_ff, a_in;
   sq_stage_type      b_ff, b_in;
   sum_stage_type     c_ff, c_in;
   sqrt_cell_type     sq1 [SQRT_STEPS+1];
   dvec_type          s1_ff [SQRT_STEPS];
   dir_stage_type     d_ff, d_in;
   logic signed [32:0] rad_diff;
   div_in_stage_type  d2_ff, d2_in;
   div_cell_type      dvc [DIV_STEPS+1];
   div_cell_type      dvs [DIV_STEPS+1];
   dir_side_type      s2_ff [DIV_STEPS];
   cs_stage_type      e_ff, e_in;
   prod_stage_type    f_ff, f_in;
   xy_stage_type      g_ff, g_in;
   vvec_type          h_ff, h_in;
   vsq_stage_type     i_ff, i_in;
   vpart_stage_type   j1_ff, j1_in;
   vsum_stage_type    j2_ff, j2_in;
   sqrt_cell_type     sq2 [SQRT_STEPS+1];
   lim_side_type      s3_ff [SQRT_STEPS];
   scale_stage_type   k_ff, k_in;
   div_cell_type      dvl [3][DIV_STEPS+1];
   lim_side_type      s4_ff [DIV_STEPS];
   rsp_type           l_ff, l_in;

   // ---------------------------------------------------------------- config
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= 24'd65536;
         radius_ff <= '0;
         omega_ff  <= '0;
         ofs_x_ff  <= '0;
         ofs_y_ff  <= '0;
         ofs_z_ff  <= '0;
         limit_ff  <= '0;
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[ADDR_W-1:2])
            REG_GAIN:   gain_ff   <= pwdata[23:0];
            REG_RADIUS: radius_ff <= pwdata[30:0];
            REG_OMEGA:  omega_ff  <= $signed(pwdata[23:0]);
            REG_OFS_X:  ofs_x_ff  <= $signed(pwdata);
            REG_OFS_Y:  ofs_y_ff  <= $signed(pwdata);
            REG_OFS_Z:  ofs_z_ff  <= $signed(pwdata);
            REG_LIMIT:  limit_ff  <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[ADDR_W-1:2])
         REG_GAIN:   prdata = {8'd0, gain_ff};
         REG_RADIUS: prdata = {1'b0, radius_ff};
         REG_OMEGA:  prdata = {{8{omega_ff[23]}}, omega_ff};
         REG_OFS_X:  prdata = ofs_x_ff;
         REG_OFS_Y:  prdata = ofs_y_ff;
         REG_OFS_Z:  prdata = ofs_z_ff;
         REG_LIMIT:  prdata = {1'b0, limit_ff};
         default:    prdata = '0;
      endcase
   end

   // tangential speed and squared limit depend on registers only
   assign rw_prod = $signed({1'b0, radius_ff}) * omega_ff;

   always_ff @(posedge clock) begin
      qrw_ff <= sat32(shr_rnd(66'(rw_prod), 16));
      lsq_ff <= 62'(limit_ff) * 62'(limit_ff);
   end

   // --------------------------------------------------------- flow control
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[PIPE_STAGES-2:0], req_valid};
      end
   end

   // ------------------------------------------------------ offset, radius
   always_comb begin
      a_in.dx = sat32(66'($signed(req_data.pos_x)) - 66'($signed(req_data.centre_x))
                      - 66'(ofs_x_ff));
      a_in.dy = sat32(66'($signed(req_data.pos_y)) - 66'($signed(req_data.centre_y))
                      - 66'(ofs_y_ff));
      a_in.dz = sat32(66'($signed(req_data.pos_z)) - 66'($signed(req_data.centre_z))
                      - 66'(ofs_z_ff));

      b_in.sqx = 64'(mag32(a_ff.dx)) * 64'(mag32(a_ff.dx));
      b_in.sqy = 64'(mag32(a_ff.dy)) * 64'(mag32(a_ff.dy));
      b_in.d   = a_ff;

      c_in.sum = b_ff.sqx + b_ff.sqy;
      c_in.d   = b_ff.d;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   assign sq1[0] = '{n: c_ff.sum, rem: '0, root: '0};

   for (genvar gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt_rad
      lcvf_sqrt_cell u_cell (
         .clock     (clock),
         .advance   (advance),
         .prev_cell (sq1[gi]),
         .next_cell (sq1[gi+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff[0] <= c_ff.d;
         for (int i = 1; i < SQRT_STEPS; i++) begin
            s1_ff[i] <= s1_ff[i-1];
         end
      end
   end

   // --------------------------------------------- dividends, radial speed
   always_comb begin
      rad_diff    = $signed({1'b0, sq1[SQRT_STEPS].root}) - $signed({2'b00, radius_ff});
      d_in.numc   = {mag32(s1_ff[SQRT_STEPS-1].dx), 30'd0}
                    + 62'(sq1[SQRT_STEPS].root[31:1]);
      d_in.nums   = {mag32(s1_ff[SQRT_STEPS-1].dy), 30'd0}
                    + 62'(sq1[SQRT_STEPS].root[31:1]);
      d_in.den    = sq1[SQRT_STEPS].root;
      d_in.zero   = (sq1[SQRT_STEPS].root == '0);
      d_in.sx     = s1_ff[SQRT_STEPS-1].dx[31];
      d_in.sy     = s1_ff[SQRT_STEPS-1].dy[31];
      d_in.pprod  = $signed({1'b0, gain_ff}) * rad_diff;
      d_in.zprod  = $signed({1'b0, gain_ff}) * s1_ff[SQRT_STEPS-1].dz;

      d2_in.numc    = d_ff.numc;
      d2_in.nums    = d_ff.nums;
      d2_in.den     = d_ff.den;
      d2_in.sb.p    = sat32(-shr_rnd(66'(d_ff.pprod), 16));
      d2_in.sb.vz   = sat32(-shr_rnd(66'(d_ff.zprod), 16));
      d2_in.sb.zero = d_ff.zero;
      d2_in.sb.sx   = d_ff.sx;
      d2_in.sb.sy   = d_ff.sy;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff  <= d_in;
         d2_ff <= d2_in;
      end
   end

   // direction cosines: |d| * 2^30 / R, rounded
   assign dvc[0] = '{rem: {1'b0, d2_ff.numc[61:31]}, den: d2_ff.den, qn: d2_ff.numc[30:0]};
   assign dvs[0] = '{rem: {1'b0, d2_ff.nums[61:31]}, den: d2_ff.den, qn: d2_ff.nums[30:0]};

   for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div_dir
      lcvf_div_cell u_cos (
         .clock     (clock),
         .advance   (advance),
         .prev_cell (dvc[gi]),
         .next_cell (dvc[gi+1])
      );
      lcvf_div_cell u_sin (
         .clock     (clock),
         .advance   (advance),
         .prev_cell (dvs[gi]),
         .next_cell (dvs[gi+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff[0] <= d2_ff.sb;
         for (int i = 1; i < DIV_STEPS; i++) begin
            s2_ff[i] <= s2_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------- velocity field
   always_comb begin
      if (s2_ff[DIV_STEPS-1].zero) begin
         e_in.c = 32'sh40000000;
         e_in.s = '0;
      end else begin
         e_in.c = s2_ff[DIV_STEPS-1].sx ? -$signed({1'b0, dvc[DIV_STEPS].qn})
                                        :  $signed({1'b0, dvc[DIV_STEPS].qn});
         e_in.s = s2_ff[DIV_STEPS-1].sy ? -$signed({1'b0, dvs[DIV_STEPS].qn})
                                        :  $signed({1'b0, dvs[DIV_STEPS].qn});
      end
      e_in.p  = s2_ff[DIV_STEPS-1].p;
      e_in.vz = s2_ff[DIV_STEPS-1].vz;

      f_in.pc = e_ff.p * e_ff.c;
      f_in.qs = qrw_ff * e_ff.s;
      f_in.ps = e_ff.p * e_ff.s;
      f_in.qc = qrw_ff * e_ff.c;
      f_in.vz = e_ff.vz;

      g_in.x  = {f_ff.pc[63], f_ff.pc} - {f_ff.qs[63], f_ff.qs};
      g_in.y  = {f_ff.ps[63], f_ff.ps} + {f_ff.qc[63], f_ff.qc};
      g_in.vz = f_ff.vz;

      h_in.vx = sat32(shr_rnd({g_ff.x[64], g_ff.x}, 30));
      h_in.vy = sat32(shr_rnd({g_ff.y[64], g_ff.y}, 30));
      h_in.vz = g_ff.vz;

      i_in.sq0 = 64'(mag32(h_ff.vx)) * 64'(mag32(h_ff.vx));
      i_in.sq1 = 64'(mag32(h_ff.vy)) * 64'(mag32(h_ff.vy));
      i_in.sq2 = 64'(mag32(h_ff.vz)) * 64'(mag32(h_ff.vz));
      i_in.v   = h_ff;

      j1_in.s01 = i_ff.sq0 + i_ff.sq1;
      j1_in.sq2 = i_ff.sq2;
      j1_in.v   = i_ff.v;

      j2_in.sum = j1_ff.s01 + j1_ff.sq2;
      j2_in.v   = j1_ff.v;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_ff  <= e_in;
         f_ff  <= f_in;
         g_ff  <= g_in;
         h_ff  <= h_in;
         i_ff  <= i_in;
         j1_ff <= j1_in;
         j2_ff <= j2_in;
      end
   end

   // ----------------------------------------------------------- speed limit
   assign sq2[0] = '{n: j2_ff.sum, rem: '0, root: '0};

   for (genvar gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt_len
      lcvf_sqrt_cell u_cell (
         .clock     (clock),
         .advance   (advance),
         .prev_cell (sq2[gi]),
         .next_cell (sq2[gi+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff[0] <= '{v: j2_ff.v, lim: (j2_ff.sum > {2'b00, lsq_ff})};
         for (int i = 1; i < SQRT_STEPS; i++) begin
            s3_ff[i] <= s3_ff[i-1];
         end
      end
   end

   always_comb begin
      k_in.pr0 = 62'(mag32(s3_ff[SQRT_STEPS-1].v.vx)) * 62'(limit_ff);
      k_in.pr1 = 62'(mag32(s3_ff[SQRT_STEPS-1].v.vy)) * 62'(limit_ff);
      k_in.pr2 = 62'(mag32(s3_ff[SQRT_STEPS-1].v.vz)) * 62'(limit_ff);
      k_in.den = sq2[SQRT_STEPS].root;
      k_in.sb  = s3_ff[SQRT_STEPS-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         k_ff <= k_in;
      end
   end

   // |v| * L / N, truncated
   assign dvl[0][0] = '{rem: {1'b0, k_ff.pr0[61:31]}, den: k_ff.den, qn: k_ff.pr0[30:0]};
   assign dvl[1][0] = '{rem: {1'b0, k_ff.pr1[61:31]}, den: k_ff.den, qn: k_ff.pr1[30:0]};
   assign dvl[2][0] = '{rem: {1'b0, k_ff.pr2[61:31]}, den: k_ff.den, qn: k_ff.pr2[30:0]};

   for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div_scale
         lcvf_div_cell u_cell (
            .clock     (clock),
            .advance   (advance),
            .prev_cell (dvl[gl][gi]),
            .next_cell (dvl[gl][gi+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ff[0] <= k_ff.sb;
         for (int i = 1; i < DIV_STEPS; i++) begin
            s4_ff[i] <= s4_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      l_in.was_limited = s4_ff[DIV_STEPS-1].lim;
      if (s4_ff[DIV_STEPS-1].lim) begin
         l_in.vel_x = s4_ff[DIV_STEPS-1].v.vx[31] ? -$signed({1'b0, dvl[0][DIV_STEPS].qn})
                                                  :  $signed({1'b0, dvl[0][DIV_STEPS].qn});
         l_in.vel_y = s4_ff[DIV_STEPS-1].v.vy[31] ? -$signed({1'b0, dvl[1][DIV_STEPS].qn})
                                                  :  $signed({1'b0, dvl[1][DIV_STEPS].qn});
         l_in.vel_z = s4_ff[DIV_STEPS-1].v.vz[31] ? -$signed({1'b0, dvl[2][DIV_STEPS].qn})
                                                  :  $signed({1'b0, dvl[2][DIV_STEPS].qn});
      end else begin
         l_in.vel_x = s4_ff[DIV_STEPS-1].v.vx;
         l_in.vel_y = s4_ff[DIV_STEPS-1].v.vy;
         l_in.vel_z = s4_ff[DIV_STEPS-1].v.vz;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l_ff <= l_in;
      end
   end

   assign rsp_data = l_ff;

endmodule

// ===== tb/limit_cycle_velocity_field_tb.sv =====
// ----------------------------------------------------------------------------
// limit_cycle_velocity_field_tb: self-checking bench for the velocity field
// Drives position beats through several register settings, predicts each
// velocity beat in fixed point and checks results in order, with random
// stalls on both sides and one long output hold that backs up the pipeline.
// ----------------------------------------------------------------------------
module limit_cycle_velocity_field_tb;
   import lcvf_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 160;
   localparam int N_PHASES     = 6;
   localparam int PHASE_ITEMS  = 320;

   // velocity prediction and in-order result check
   class velocity_scoreboard;
      longint unsigned gain, radius, limit;
      longint          omega;
      longint          ofs[3];
      rsp_type         pending[$];
      int              errors, n_in, n_out, n_limited;

      function new();
         gain = 65536; radius = 0; limit = 0; omega = 0;
         ofs[0] = 0; ofs[1] = 0; ofs[2] = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] val);
         case (idx)
            REG_GAIN:   gain   = val[23:0];
            REG_RADIUS: radius = val[30:0];
            REG_OMEGA:  omega  = longint'($signed(val[23:0]));
            REG_OFS_X:  ofs[0] = longint'($signed(val));
            REG_OFS_Y:  ofs[1] = longint'($signed(val));
            REG_OFS_Z:  ofs[2] = longint'($signed(val));
            REG_LIMIT:  limit  = val[30:0];
            default: ;
         endcase
      endfunction

      static function longint unsigned isqrt(longint unsigned n);
         longint unsigned res, bit_w;
         res = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > n) bit_w >>= 2;
         while (bit_w != 0) begin
            if (n >= res + bit_w) begin
               n   = n - (res + bit_w);
               res = (res >> 1) + bit_w;
            end else begin
               res = res >> 1;
            end
            bit_w >>= 2;
         end
         return res;
      endfunction

      static function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      static function longint unsigned mag(longint v);
         return v < 0 ? longint'(-v) : v;
      endfunction

      static function longint round_shr(longint v, int k);
         longint unsigned m;
         m = (mag(v) + (64'd1 << (k - 1))) >> k;
         return v < 0 ? -longint'(m) : longint'(m);
      endfunction

      function rsp_type velocity(req_type x);
         longint d[3], v[3], c, s, p, q;
         longint unsigned rad, sum, n, m, mc, ms;
         longint pos[3], cen[3];
         rsp_type y;
         pos[0] = x.pos_x; pos[1] = x.pos_y; pos[2] = x.pos_z;
         cen[0] = x.centre_x; cen[1] = x.centre_y; cen[2] = x.centre_z;
         for (int i = 0; i < 3; i++) d[i] = clamp32(pos[i] - cen[i] - ofs[i]);
         rad = isqrt(mag(d[0]) * mag(d[0]) + mag(d[1]) * mag(d[1]));
         if (rad == 0) begin
            c = 64'sd1 << 30;
            s = 0;
         end else begin
            mc = ((mag(d[0]) << 30) + rad / 2) / rad;
            ms = ((mag(d[1]) << 30) + rad / 2) / rad;
            c = d[0] < 0 ? -longint'(mc) : longint'(mc);
            s = d[1] < 0 ? -longint'(ms) : longint'(ms);
         end
         p = clamp32(-round_shr(longint'(gain) * (longint'(rad) - longint'(radius)), 16));
         q = clamp32(round_shr(longint'(radius) * omega, 16));
         v[0] = clamp32(round_shr(p * c - q * s, 30));
         v[1] = clamp32(round_shr(p * s + q * c, 30));
         v[2] = clamp32(-round_shr(longint'(gain) * d[2], 16));
         sum = 0;
         for (int i = 0; i < 3; i++) sum += mag(v[i]) * mag(v[i]);
         y.was_limited = sum > limit * limit;
         if (y.was_limited) begin
            n = isqrt(sum);
            for (int i = 0; i < 3; i++) begin
               m = mag(v[i]) * limit / n;
               v[i] = v[i] < 0 ? -longint'(m) : longint'(m);
            end
         end
         y.vel_x = v[0][31:0];
         y.vel_y = v[1][31:0];
         y.vel_z = v[2][31:0];
         return y;
      endfunction

      function void note_request(req_type x);
         pending.push_back(velocity(x));
         n_in++;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch on result %0d: %s got %h, want %h", n_out, what, got, want);
         errors++;
      endtask

      task check_result(rsp_type y);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("unexpected result beat %h", y);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (y.vel_x !== e.vel_x) report("vel_x", y.vel_x, e.vel_x);
         if (y.vel_y !== e.vel_y) report("vel_y", y.vel_y, e.vel_y);
         if (y.vel_z !== e.vel_z) report("vel_z", y.vel_z, e.vel_z);
         if (y.was_limited !== e.was_limited)
            report("was_limited", 32'(y.was_limited), 32'(e.was_limited));
         if (e.was_limited) n_limited++;
         n_out++;
      endtask
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   rsp_type           rsp_data;
   logic              psel = 0;
   logic              penable = 0;
   logic              pwrite = 0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   velocity_scoreboard sb = new();
   bit                 quiet = 0;
   bit                 hold_now = 0;
   int                 idle_count = 0;

   limit_cycle_velocity_field dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #4 clock = ~clock;

   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= ADDR_W'(idx) << 2; pwdata <= val;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.set_reg(idx, val);
   endtask

   task automatic send_beat(req_type x);
      @(negedge clock);
      req_valid <= 1;
      req_data  <= x;
      do @(posedge clock); while (!req_ready);
      sb.note_request(x);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat ($urandom_range(1, 12) - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic req_type beat(int px, int py, int pz, int cx, int cy, int cz);
      req_type x;
      x.pos_x = px; x.pos_y = py; x.pos_z = pz;
      x.centre_x = cx; x.centre_y = cy; x.centre_z = cz;
      return x;
   endfunction

   function automatic int near(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic req_type random_beat();
      req_type x;
      case ($urandom_range(0, 3))
         0: x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         1: begin
            x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            x.centre_x = x.pos_x - near(1 << 22);
            x.centre_y = x.pos_y - near(1 << 22);
            x.centre_z = x.pos_z - near(1 << 20);
         end
         2: begin
            x = beat(near(1 << 24), near(1 << 24), near(1 << 24),
                     near(1 << 22), near(1 << 22), near(1 << 22));
         end
         default: begin
            x = beat(near(1 << 26), 0, near(1 << 18), 0, 0, 0);
            if ($urandom_range(0, 1)) begin
               x.pos_y = x.pos_x;
               x.pos_x = 0;
            end
         end
      endcase
      return x;
   endfunction

   task automatic directed_beats();
      int mx, mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      send_beat(beat(0, 0, 0, 0, 0, 0));
      send_beat(beat(mx, mx, mx, mn, mn, mn));
      send_beat(beat(mn, mn, mn, mx, mx, mx));
      send_beat(beat(5 << 16, 7 << 16, 3 << 16, 5 << 16, 7 << 16, 0));
      send_beat(beat(-(3 << 16), 0, 0, 0, 0, 0));
      send_beat(beat(0, 12 << 16, -(1 << 16), 0, 0, 0));
      send_beat(beat(10 << 16, 0, 0, 0, 0, 0));
      send_beat(beat(1, -1, 1, 0, 0, 0));
      send_beat(beat(mx, mx, mx, mx, mx, mx));
      send_beat(beat(mn, 0, mx, 0, mn, 0));
   endtask

   // receiver: random stall bursts, one long hold on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_now) begin
            hold_now = 0;
            rsp_ready <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] cfg[N_PHASES][7];
      cfg[1] = '{32'hffffff, 32'h7fffffff, 32'h800000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff};
      cfg[2] = '{32'h10000, 32'ha0000, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h7fffffff};
      cfg[3] = '{32'h0, 32'h0, 32'h7fffff, 32'h0, 32'h0, 32'h0, 32'h0};
      cfg[4] = '{32'h20000, 32'h140000, 32'hfe0000, 32'h30000, 32'hfffd0000,
                 32'h8000, 32'h50000};
      for (int k = 0; k < 7; k++) cfg[0][k] = 0;
      for (int k = 0; k < 7; k++) cfg[5][k] = $urandom;
      cfg[5][REG_GAIN] &= 32'h3ffff;
      cfg[5][REG_RADIUS] &= 32'h3fffff;
      cfg[5][REG_OMEGA] &= 32'hffffff;
      cfg[5][REG_LIMIT] &= 32'h3fffff;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph > 0) begin
            wait_drained();
            for (int k = 0; k < 7; k++) csr_write(reg_index_type'(k), cfg[ph][k]);
         end
         if (ph == 0 || ph == 2) directed_beats();
         if (ph == 1) hold_now = 1;
         if (ph == N_PHASES - 1) quiet = 1;
         for (int i = 0; i < PHASE_ITEMS; i++) send_beat(random_beat());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests, %0d results (%0d speed-limited) over %0d settings",
               sb.n_in, sb.n_out, sb.n_limited, N_PHASES);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
